[rtl/sbgc_pkg.sv]
// shared types, constants and field widths for the segmented buffer gather copy
package sbgc_pkg;

	localparam int DEF_MAX_BLOCKS  = 8;
	localparam int DEF_STORE_BYTES = 1024;
	localparam int DEF_MAX_COPY    = 64;

	localparam int CMD_W   = 2;
	localparam int LEN_W   = 11;
	localparam int BASE_W  = 10;
	localparam int SADDR_W = 10;
	localparam int BYTE_W  = 8;
	localparam int START_W = 13;
	localparam int CLEN_W  = 7;
	localparam int STAT_W  = 2;

	// address reduction works on base plus offset, below 1 << RED_W
	localparam int RED_W = 12;
	localparam int SUB_W = 17;
	localparam int KW    = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 2'd0,
		CMD_WRITE  = 2'd1,
		CMD_COPY   = 2'd2
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_PAST_END  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_REDUCE,
		S_WRITE,
		S_EMIT,
		S_FINAL,
		S_RESP
	} state_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} store_ctl_t;

endpackage

[rtl/segmented_buffer_gather_copy.sv]
// top level: descriptor table, copy sequencer and result register
// Every command takes one input transfer and gives its results on the result
// channel; the block takes no new command until the last result of the current
// one has been loaded into the result register. Append and unused commands
// give a single result, which passes through the response state. A store write first
// reduces the address modulo STORE_BYTES by shift and subtract, one step a
// cycle, RED_TOP + 1 steps (3 at the default size), then writes the byte and
// gives its result through the response state. A copy walks the table one
// descriptor a cycle, reduces the store address at the start block and at each
// later block entered (RED_TOP + 1 steps each), then reads one byte a cycle
// from the single store port while the result register can take it. The result
// register stalls the byte stream whenever it holds a result that the result
// channel is not ready to take.
module segmented_buffer_gather_copy import sbgc_pkg::*; #(
	parameter int MAX_BLOCKS  = DEF_MAX_BLOCKS,
	parameter int STORE_BYTES = DEF_STORE_BYTES,
	parameter int MAX_COPY    = DEF_MAX_COPY
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic [CMD_W-1:0]   cmd,
	input  logic [LEN_W-1:0]   block_length,
	input  logic [BASE_W-1:0]  block_base,
	input  logic [SADDR_W-1:0] store_address,
	input  logic [BYTE_W-1:0]  store_byte,
	input  logic [START_W-1:0] copy_start,
	input  logic [CLEN_W-1:0]  copy_length,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [BYTE_W-1:0]  data_byte,
	output logic               byte_valid,
	output logic               last,
	output logic [STAT_W-1:0]  status,
	output logic [CLEN_W-1:0]  copied_count
);

	localparam int CW      = $clog2(MAX_BLOCKS + 1);
	localparam int IW      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int AW      = $clog2(STORE_BYTES);
	localparam int RED_TOP = $clog2((1 << RED_W) / STORE_BYTES);

	state_t state_q, state_d;

	logic [CW-1:0]      count_q, count_d;
	logic [CW-1:0]      idx_q, idx_d;
	logic [START_W-1:0] rem_q, rem_d;
	logic [CLEN_W-1:0]  want_q, want_d;
	logic [CLEN_W-1:0]  n_q, n_d;
	logic [RED_W-1:0]   red_q, red_d;
	logic [KW-1:0]      k_q, k_d;
	logic [AW-1:0]      addr_q, addr_d;
	logic               red_wr_q, red_wr_d;
	logic               need_addr_q, need_addr_d;
	logic               pend_q, pend_d;
	status_t            rsp_q, rsp_d;
	logic [BYTE_W-1:0]  wbyte_q;

	logic               res_valid_q, res_valid_d;
	logic [BYTE_W-1:0]  data_q, data_d;
	logic               bv_q, bv_d;
	logic               last_q, last_d;
	status_t            status_q, status_d;
	logic [CLEN_W-1:0]  cnt_q, cnt_d;

	logic [LEN_W-1:0]   lengths_q [MAX_BLOCKS];
	logic [BASE_W-1:0]  bases_q [MAX_BLOCKS];
	logic               tbl_we;

	logic [LEN_W-1:0]   len_rd;
	logic [BASE_W-1:0]  base_rd;
	logic [SUB_W-1:0]   op_a, op_b, div_shift;
	logic [SUB_W:0]     diff;
	logic               borrow;
	logic [RED_W-1:0]   red_next;
	logic [AW-1:0]      addr_inc;
	logic               out_free;

	store_ctl_t         st_ctl;
	logic [BYTE_W-1:0]  rdata_s1;

	sbgc_store #(
		.DEPTH(STORE_BYTES),
		.AW   (AW)
	) u_store (
		.clk     (clk),
		.ctl     (st_ctl),
		.addr    (addr_q),
		.wdata   (wbyte_q),
		.rdata_s1(rdata_s1)
	);

	assign len_rd    = lengths_q[idx_q[IW-1:0]];
	assign base_rd   = bases_q[idx_q[IW-1:0]];
	assign div_shift = SUB_W'(STORE_BYTES) << k_q;

	// shared subtract and compare unit
	always_comb begin
		if (state_q == S_REDUCE) begin
			op_a = SUB_W'(red_q);
			op_b = div_shift;
		end else begin
			op_a = SUB_W'(rem_q);
			op_b = SUB_W'(len_rd);
		end
	end

	assign diff     = {1'b0, op_a} - {1'b0, op_b};
	assign borrow   = diff[SUB_W];
	assign red_next = borrow ? red_q : diff[RED_W-1:0];
	assign addr_inc = (addr_q == AW'(STORE_BYTES - 1)) ? '0 : addr_q + 1'b1;
	assign out_free = !res_valid_q || result_ready;

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		idx_d       = idx_q;
		rem_d       = rem_q;
		want_d      = want_q;
		n_d         = n_q;
		red_d       = red_q;
		k_d         = k_q;
		addr_d      = addr_q;
		red_wr_d    = red_wr_q;
		need_addr_d = need_addr_q;
		pend_d      = pend_q;
		rsp_d       = rsp_q;
		res_valid_d = res_valid_q;
		data_d      = data_q;
		bv_d        = bv_q;
		last_d      = last_q;
		status_d    = status_q;
		cnt_d       = cnt_q;
		tbl_we      = 1'b0;
		st_ctl      = '0;
		item_ready  = (state_q == S_IDLE);

		if (res_valid_q && result_ready) begin
			res_valid_d = 1'b0;
		end

		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					case (cmd)
						CMD_APPEND: begin
							if (count_q >= CW'(MAX_BLOCKS)) begin
								rsp_d = ST_FULL;
							end else begin
								tbl_we  = 1'b1;
								count_d = count_q + 1'b1;
								rsp_d   = ST_OK;
							end
							state_d = S_RESP;
						end
						CMD_WRITE: begin
							red_d    = RED_W'(store_address);
							k_d      = KW'(RED_TOP);
							red_wr_d = 1'b1;
							state_d  = S_REDUCE;
						end
						CMD_COPY: begin
							rem_d   = copy_start;
							idx_d   = '0;
							n_d     = '0;
							want_d  = (copy_length > CLEN_W'(MAX_COPY)) ?
								CLEN_W'(MAX_COPY) : copy_length;
							state_d = S_SEARCH;
						end
						default: begin
							rsp_d   = ST_OK;
							state_d = S_RESP;
						end
					endcase
				end
			end
			S_SEARCH: begin
				if (idx_q >= count_q) begin
					rsp_d   = ST_NOT_FOUND;
					state_d = S_RESP;
				end else if (borrow) begin
					if (want_q == '0) begin
						rsp_d   = ST_OK;
						state_d = S_RESP;
					end else begin
						need_addr_d = 1'b1;
						state_d     = S_EMIT;
					end
				end else begin
					rem_d = diff[START_W-1:0];
					idx_d = idx_q + 1'b1;
				end
			end
			S_REDUCE: begin
				red_d = red_next;
				if (k_q == '0) begin
					addr_d = AW'(red_next);
					if (red_wr_q) begin
						state_d = S_WRITE;
					end else begin
						need_addr_d = 1'b0;
						state_d     = S_EMIT;
					end
				end else begin
					k_d = k_q - 1'b1;
				end
			end
			S_WRITE: begin
				st_ctl.wr_en = 1'b1;
				rsp_d        = ST_OK;
				state_d      = S_RESP;
			end
			S_EMIT: begin
				if (n_q == want_q || idx_q >= count_q) begin
					state_d = S_FINAL;
				end else if (!borrow) begin
					// block used up or empty, move to the next one
					idx_d       = idx_q + 1'b1;
					rem_d       = '0;
					need_addr_d = 1'b1;
				end else if (need_addr_q) begin
					red_d    = RED_W'(base_rd) + RED_W'(rem_q);
					k_d      = KW'(RED_TOP);
					red_wr_d = 1'b0;
					state_d  = S_REDUCE;
				end else if (!pend_q || out_free) begin
					st_ctl.rd_en = 1'b1;
					addr_d       = addr_inc;
					rem_d        = rem_q + 1'b1;
					n_d          = n_q + 1'b1;
					pend_d       = 1'b1;
					if (pend_q) begin
						res_valid_d = 1'b1;
						data_d      = rdata_s1;
						bv_d        = 1'b1;
						last_d      = 1'b0;
						status_d    = ST_OK;
						cnt_d       = '0;
					end
				end
			end
			S_FINAL: begin
				if (out_free) begin
					res_valid_d = 1'b1;
					data_d      = rdata_s1;
					bv_d        = 1'b1;
					last_d      = 1'b1;
					status_d    = (n_q < want_q) ? ST_PAST_END : ST_OK;
					cnt_d       = n_q;
					pend_d      = 1'b0;
					state_d     = S_IDLE;
				end
			end
			S_RESP: begin
				if (out_free) begin
					res_valid_d = 1'b1;
					data_d      = '0;
					bv_d        = 1'b0;
					last_d      = 1'b1;
					status_d    = rsp_q;
					cnt_d       = '0;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			pend_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			pend_q      <= pend_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q       <= idx_d;
		rem_q       <= rem_d;
		want_q      <= want_d;
		n_q         <= n_d;
		red_q       <= red_d;
		k_q         <= k_d;
		addr_q      <= addr_d;
		red_wr_q    <= red_wr_d;
		need_addr_q <= need_addr_d;
		rsp_q       <= rsp_d;
		data_q      <= data_d;
		bv_q        <= bv_d;
		last_q      <= last_d;
		status_q    <= status_d;
		cnt_q       <= cnt_d;
		if (item_valid && item_ready) begin
			wbyte_q <= store_byte;
		end
		if (tbl_we) begin
			lengths_q[count_q[IW-1:0]] <= block_length;
			bases_q[count_q[IW-1:0]]   <= block_base;
		end
	end

	assign result_valid = res_valid_q;
	assign data_byte    = data_q;
	assign byte_valid   = bv_q;
	assign last         = last_q;
	assign status       = status_q;
	assign copied_count = cnt_q;

endmodule

[rtl/sbgc_store.sv]
// byte store memory with one shared address and a registered read port
module sbgc_store import sbgc_pkg::*; #(
	parameter int DEPTH = DEF_STORE_BYTES,
	parameter int AW    = $clog2(DEF_STORE_BYTES)
) (
	input  logic              clk,
	input  store_ctl_t        ctl,
	input  logic [AW-1:0]     addr,
	input  logic [BYTE_W-1:0] wdata,
	output logic [BYTE_W-1:0] rdata_s1
);

	logic [BYTE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rdata_s1 <= mem[addr];
		end
	end

endmodule

[bench/tb.sv]
// testbench for segmented_buffer_gather_copy: gather predictor, stimulus tasks and top module
`timescale 1ns / 100ps

module tb import sbgc_pkg::*;;

	localparam int MAX_BLOCKS   = DEF_MAX_BLOCKS;
	localparam int STORE_BYTES  = DEF_STORE_BYTES;
	localparam int MAX_COPY     = DEF_MAX_COPY;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int STREAM_END   = 2097;
	localparam int RANDOM_ITEMS = 360;
	localparam int HOLD_CYCLES  = 400;
	localparam int QUIET_LIMIT  = 3000;

	typedef struct {
		logic [CMD_W-1:0]   cmd;
		logic [LEN_W-1:0]   block_length;
		logic [BASE_W-1:0]  block_base;
		logic [SADDR_W-1:0] store_address;
		logic [BYTE_W-1:0]  store_byte;
		logic [START_W-1:0] copy_start;
		logic [CLEN_W-1:0]  copy_length;
	} command_t;

	typedef struct {
		logic [BYTE_W-1:0] data;
		logic              valid;
		logic              last;
		logic [STAT_W-1:0] status;
		logic [CLEN_W-1:0] count;
	} result_t;

	class gather_checker;
		result_t           pending_results[$];
		logic [LEN_W-1:0]  lens[MAX_BLOCKS];
		logic [BASE_W-1:0] bases[MAX_BLOCKS];
		int                nblocks;
		logic [BYTE_W-1:0] store[STORE_BYTES];
		bit                written[STORE_BYTES];
		int errors, n_commands, n_copies, n_past_end;
		int n_not_found, n_full, n_bytes, n_results;

		// store addresses a copy reads, in stream order
		function void slice_addresses(input int start, input int req, output bit found,
				output int want, output int addrs[$]);
			int rem;
			int idx;
			addrs = {};
			found = 1'b0;
			want = (req > MAX_COPY) ? MAX_COPY : req;
			rem = start;
			idx = 0;
			while (idx < nblocks) begin
				if (rem < int'(lens[idx])) begin
					found = 1'b1;
					break;
				end
				rem -= int'(lens[idx]);
				idx++;
			end
			if (!found)
				return;
			while (addrs.size() < want && idx < nblocks) begin
				if (rem >= int'(lens[idx])) begin
					idx++;
					rem = 0;
				end else begin
					addrs = {addrs, (int'(bases[idx]) + rem) % STORE_BYTES};
					rem++;
				end
			end
		endfunction

		function void note_command(input command_t c);
			result_t r;
			int addrs[$];
			bit found;
			int want;
			n_commands++;
			r.data = '0;
			r.valid = 1'b0;
			r.last = 1'b1;
			r.status = ST_OK;
			r.count = '0;
			case (c.cmd)
				CMD_APPEND: begin
					if (nblocks >= MAX_BLOCKS) begin
						r.status = ST_FULL;
						n_full++;
					end else begin
						lens[nblocks] = c.block_length;
						bases[nblocks] = c.block_base;
						nblocks++;
					end
				end
				CMD_WRITE: begin
					store[int'(c.store_address) % STORE_BYTES] = c.store_byte;
					written[int'(c.store_address) % STORE_BYTES] = 1'b1;
				end
				CMD_COPY: begin
					n_copies++;
					slice_addresses(int'(c.copy_start), int'(c.copy_length), found,
						want, addrs);
					if (!found) begin
						r.status = ST_NOT_FOUND;
						n_not_found++;
					end else if (addrs.size() > 0) begin
						foreach (addrs[k]) begin
							r.data = store[addrs[k]];
							r.valid = 1'b1;
							r.last = (k == addrs.size() - 1);
							r.status = ST_OK;
							r.count = '0;
							if (r.last) begin
								r.status = (addrs.size() < want) ? ST_PAST_END : ST_OK;
								r.count = CLEN_W'(addrs.size());
							end
							pending_results = {pending_results, r};
						end
						if (addrs.size() < want)
							n_past_end++;
						n_bytes += addrs.size();
						return;
					end
				end
				default: ;
			endcase
			pending_results = {pending_results, r};
		endfunction

		function void check_result(input result_t got);
			result_t exp_r;
			n_results++;
			if (pending_results.size() == 0) begin
				$error("unexpected result transfer: data_byte %0d last %0d status %0d",
					got.data, got.last, got.status);
				errors++;
				return;
			end
			exp_r = pending_results.pop_front();
			if (got.data !== exp_r.data) begin
				$error("data_byte: expected %0d, got %0d", exp_r.data, got.data);
				errors++;
			end
			if (got.valid !== exp_r.valid) begin
				$error("byte_valid: expected %0d, got %0d", exp_r.valid, got.valid);
				errors++;
			end
			if (got.last !== exp_r.last) begin
				$error("last: expected %0d, got %0d", exp_r.last, got.last);
				errors++;
			end
			if (got.status !== exp_r.status) begin
				$error("status: expected %0d, got %0d", exp_r.status, got.status);
				errors++;
			end
			if (got.count !== exp_r.count) begin
				$error("copied_count: expected %0d, got %0d", exp_r.count, got.count);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               item_valid;
	logic               item_ready;
	logic [CMD_W-1:0]   cmd;
	logic [LEN_W-1:0]   block_length;
	logic [BASE_W-1:0]  block_base;
	logic [SADDR_W-1:0] store_address;
	logic [BYTE_W-1:0]  store_byte;
	logic [START_W-1:0] copy_start;
	logic [CLEN_W-1:0]  copy_length;
	logic               result_valid;
	logic               result_ready;
	logic [BYTE_W-1:0]  data_byte;
	logic               byte_valid;
	logic               last;
	logic [STAT_W-1:0]  status;
	logic [CLEN_W-1:0]  copied_count;

	gather_checker sb = new;
	int src_gap_pct = 20;
	int sink_stall_pct = 20;
	int work_items;
	int quiet_cycles;
	bit held_off;

	segmented_buffer_gather_copy i_dut (
		.clk,
		.arst_n,
		.item_valid,
		.item_ready,
		.cmd,
		.block_length,
		.block_base,
		.store_address,
		.store_byte,
		.copy_start,
		.copy_length,
		.result_valid,
		.result_ready,
		.data_byte,
		.byte_valid,
		.last,
		.status,
		.copied_count
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic command_t random_fields(input logic [CMD_W-1:0] c);
		command_t it;
		it.cmd = c;
		it.block_length = LEN_W'($urandom_range(0, 1024));
		it.block_base = BASE_W'($urandom_range(0, 1023));
		it.store_address = SADDR_W'($urandom_range(0, 1023));
		it.store_byte = BYTE_W'($urandom_range(0, 255));
		it.copy_start = START_W'($urandom_range(0, 8191));
		it.copy_length = CLEN_W'($urandom_range(0, 127));
		return it;
	endfunction

	// called at a rising edge; returns at the edge where the transfer happens
	task automatic send_command(input command_t it);
		if (src_gap_pct > 0 && $urandom_range(0, 99) < src_gap_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		item_valid <= 1'b1;
		cmd <= it.cmd;
		block_length <= it.block_length;
		block_base <= it.block_base;
		store_address <= it.store_address;
		store_byte <= it.store_byte;
		copy_start <= it.copy_start;
		copy_length <= it.copy_length;
		do @(posedge clk); while (!item_ready);
		sb.note_command(it);
		work_items++;
	endtask

	task automatic append_block(input int len, input int base);
		command_t it;
		it = random_fields(CMD_APPEND);
		it.block_length = LEN_W'(len);
		it.block_base = BASE_W'(base);
		send_command(it);
	endtask

	task automatic store_write(input int addr, input int val);
		command_t it;
		it = random_fields(CMD_WRITE);
		it.store_address = SADDR_W'(addr);
		it.store_byte = BYTE_W'(val);
		send_command(it);
	endtask

	// fills any store byte the slice would read before it was written, then copies
	task automatic copy_slice(input int start, input int len);
		command_t it;
		int addrs[$];
		bit found;
		int want;
		sb.slice_addresses(start, len, found, want, addrs);
		foreach (addrs[k])
			if (!sb.written[addrs[k]])
				store_write(addrs[k], $urandom_range(0, 255));
		it = random_fields(CMD_COPY);
		it.copy_start = START_W'(start);
		it.copy_length = CLEN_W'(len);
		send_command(it);
	endtask

	initial begin
		command_t it;
		int edges[9];
		int roll;
		int start;
		int len;
		int next_switch;
		edges = '{0, 6, 6, 7, 47, 1071, 1071, 1074, 2097};
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		cmd <= CMD_APPEND;
		block_length <= '0;
		block_base <= '0;
		store_address <= '0;
		store_byte <= '0;
		copy_start <= '0;
		copy_length <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		it = random_fields(CMD_UNUSED);
		send_command(it);
		copy_slice(0, 0);
		copy_slice(8191, 64);
		append_block(6, 1021);
		append_block(0, 512);
		append_block(1, 1023);
		copy_slice(0, 10);
		copy_slice(7, 1);
		append_block(40, 100);
		append_block(1024, 700);
		append_block(0, 0);
		append_block(3, 0);
		append_block(1023, 513);
		append_block(1024, 1023);
		store_write(0, 0);
		store_write(1023, 255);
		copy_slice(0, 127);
		copy_slice(47, 0);
		copy_slice(2090, 20);
		copy_slice(2097, 0);
		copy_slice(1070, 5);
		copy_slice(2096, 1);
		copy_slice(5, 64);

		next_switch = 0;
		while (work_items < RANDOM_ITEMS) begin
			if (work_items >= RANDOM_ITEMS - 60) begin
				src_gap_pct = 0;
				sink_stall_pct = 0;
			end else if (work_items >= next_switch) begin
				src_gap_pct = 15 * $urandom_range(0, 2);
				sink_stall_pct = 15 * $urandom_range(0, 2);
				next_switch = work_items + 40;
			end
			roll = $urandom_range(0, 99);
			if (roll < 50) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: start = $urandom_range(0, STREAM_END - 1);
					4, 5: start = edges[$urandom_range(0, 8)] +
						$urandom_range(0, 4) - 2;
					6: start = STREAM_END - $urandom_range(0, 70);
					7: start = $urandom_range(STREAM_END, 8191);
					default: start = $urandom_range(0, 8191);
				endcase
				if (start < 0)
					start = 0;
				case ($urandom_range(0, 19))
					0, 1, 2, 3, 4, 5, 6, 7, 8, 9: len = $urandom_range(0, 16);
					10, 11, 12, 13, 14, 15: len = $urandom_range(0, 64);
					16, 17, 18: len = 64;
					default: len = $urandom_range(65, 127);
				endcase
				copy_slice(start, len);
			end else if (roll < 85) begin
				store_write($urandom_range(0, 1023), $urandom_range(0, 255));
			end else if (roll < 93) begin
				it = random_fields(CMD_APPEND);
				send_command(it);
			end else begin
				it = random_fields(CMD_UNUSED);
				send_command(it);
			end
		end
		item_valid <= 1'b0;

		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("%0d commands, %0d copies (%0d past end, %0d not found), %0d full appends",
			sb.n_commands, sb.n_copies, sb.n_past_end, sb.n_not_found, sb.n_full);
		$display("%0d result transfers checked, %0d of them copied bytes",
			sb.n_results, sb.n_bytes);
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off so the block backs up
	initial begin
		result_ready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!held_off && sb.n_results >= 150) begin
				held_off = 1'b1;
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				result_ready <= 1'b1;
			end else if (sink_stall_pct > 0 && $urandom_range(0, 99) < sink_stall_pct) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				result_ready <= 1'b1;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : result_monitor
		result_t got;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				got.data = data_byte;
				got.valid = byte_valid;
				got.last = last;
				got.status = status;
				got.count = copied_count;
				sb.check_result(got);
			end
			if ((item_valid && item_ready) || (result_valid && result_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("no transfer for %0d cycles, giving up", QUIET_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

endmodule
